[rtl/otc_pkg.sv]
// Shared types, constants and the microcode store of the oscillator trim calibrator.
// Depends on nothing; every other file imports it.

package otc_pkg;

    localparam int TRIM_BITS  = 8;
    localparam int TICK_BITS  = 16;
    localparam int STEP_BITS  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int UPC_W      = 5;

    localparam logic [TRIM_BITS-1:0] TRIM_MAX   = {TRIM_BITS{1'b1}};
    localparam logic [STEP_BITS-1:0] STEP_FLOOR = STEP_BITS'((2 ** TRIM_BITS - 1 + 63) / 64);
    localparam logic [TICK_BITS-1:0] DEV_NONE   = {TICK_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 2'd2;

    localparam logic [TICK_BITS-1:0] TARGET_RESET    = 16'd1000;
    localparam logic [TICK_BITS-1:0] TOLERANCE_RESET = 16'd10;
    localparam logic [STEP_BITS-1:0] MAX_STEP_RESET  = 8'd16;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    // Run phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SEARCH = 2'd1;
    localparam logic [1:0] PH_SWEEP  = 2'd2;

    // Datapath actions
    localparam logic [3:0] A_NONE        = 4'd0;
    localparam logic [3:0] A_LATCH       = 4'd1;
    localparam logic [3:0] A_INIT_RANGE  = 4'd2;
    localparam logic [3:0] A_INIT_PROBE  = 4'd3;
    localparam logic [3:0] A_SLEW        = 4'd4;
    localparam logic [3:0] A_HALVE       = 4'd5;
    localparam logic [3:0] A_MOVE_PROBE  = 4'd6;
    localparam logic [3:0] A_SWEEP_SET   = 4'd7;
    localparam logic [3:0] A_EMIT_SWL    = 4'd8;
    localparam logic [3:0] A_FIN_APPLIED = 4'd9;
    localparam logic [3:0] A_DEV         = 4'd10;
    localparam logic [3:0] A_INC_SWL     = 4'd11;
    localparam logic [3:0] A_FIN_SWL     = 4'd12;
    localparam logic [3:0] A_FIN_BEST    = 4'd13;

    // Jump conditions
    localparam logic [3:0] C_NEXT      = 4'd0;
    localparam logic [3:0] C_ALWAYS    = 4'd1;
    localparam logic [3:0] C_NO_INPUT  = 4'd2;
    localparam logic [3:0] C_OP_START  = 4'd3;
    localparam logic [3:0] C_PH_SEARCH = 4'd4;
    localparam logic [3:0] C_PH_SWEEP  = 4'd5;
    localparam logic [3:0] C_FAR       = 4'd6;
    localparam logic [3:0] C_MATCH     = 4'd7;
    localparam logic [3:0] C_STEP_ZERO = 4'd8;
    localparam logic [3:0] C_SWEEP_END = 4'd9;

    // Microcode addresses
    localparam logic [UPC_W-1:0] U_FETCH     = 5'd0;
    localparam logic [UPC_W-1:0] U_DISP      = 5'd1;
    localparam logic [UPC_W-1:0] U_DISP_SRCH = 5'd2;
    localparam logic [UPC_W-1:0] U_DISP_SWP  = 5'd3;
    localparam logic [UPC_W-1:0] U_DROP      = 5'd4;
    localparam logic [UPC_W-1:0] U_START     = 5'd5;
    localparam logic [UPC_W-1:0] U_START_PRB = 5'd6;
    localparam logic [UPC_W-1:0] U_SLEW      = 5'd7;
    localparam logic [UPC_W-1:0] U_SLEW_DONE = 5'd8;
    localparam logic [UPC_W-1:0] U_SRCH      = 5'd9;
    localparam logic [UPC_W-1:0] U_SRCH_HLV  = 5'd10;
    localparam logic [UPC_W-1:0] U_SRCH_TST  = 5'd11;
    localparam logic [UPC_W-1:0] U_SRCH_MOVE = 5'd12;
    localparam logic [UPC_W-1:0] U_SWEEP_SET = 5'd13;
    localparam logic [UPC_W-1:0] U_SWEEP_GO  = 5'd14;
    localparam logic [UPC_W-1:0] U_FIN_APP   = 5'd15;
    localparam logic [UPC_W-1:0] U_SWP       = 5'd16;
    localparam logic [UPC_W-1:0] U_SWP_DEV   = 5'd17;
    localparam logic [UPC_W-1:0] U_SWP_TST   = 5'd18;
    localparam logic [UPC_W-1:0] U_SWP_NEXT  = 5'd19;
    localparam logic [UPC_W-1:0] U_FIN_SWL   = 5'd20;
    localparam logic [UPC_W-1:0] U_FIN_BEST  = 5'd21;

    typedef struct packed {
        logic [3:0]       action;
        logic [3:0]       cond;
        logic [UPC_W-1:0] target;
        logic             emit;
    } otc_ctrl_t;

    typedef struct packed {
        logic no_input;
        logic op_start;
        logic ph_search;
        logic ph_sweep;
        logic far;
        logic match;
        logic step_zero;
        logic sweep_end;
    } otc_flags_t;

    function automatic otc_ctrl_t mk(input logic [3:0] action, input logic [3:0] cond,
                                     input logic [UPC_W-1:0] target, input logic emit);
        otc_ctrl_t w;
        w.action = action;
        w.cond   = cond;
        w.target = target;
        w.emit   = emit;
        return w;
    endfunction

    function automatic otc_ctrl_t otc_rom(input logic [UPC_W-1:0] addr);
        otc_ctrl_t w;
        case (addr)
            U_FETCH:     w = mk(A_LATCH,       C_NO_INPUT,  U_FETCH,     1'b0);
            U_DISP:      w = mk(A_NONE,        C_OP_START,  U_START,     1'b0);
            U_DISP_SRCH: w = mk(A_NONE,        C_PH_SEARCH, U_SRCH,      1'b0);
            U_DISP_SWP:  w = mk(A_NONE,        C_PH_SWEEP,  U_SWP,       1'b0);
            U_DROP:      w = mk(A_NONE,        C_ALWAYS,    U_FETCH,     1'b0);
            U_START:     w = mk(A_INIT_RANGE,  C_NEXT,      U_FETCH,     1'b0);
            U_START_PRB: w = mk(A_INIT_PROBE,  C_NEXT,      U_FETCH,     1'b0);
            U_SLEW:      w = mk(A_SLEW,        C_FAR,       U_SLEW,      1'b1);
            U_SLEW_DONE: w = mk(A_NONE,        C_ALWAYS,    U_FETCH,     1'b0);
            U_SRCH:      w = mk(A_NONE,        C_MATCH,     U_FIN_APP,   1'b0);
            U_SRCH_HLV:  w = mk(A_HALVE,       C_NEXT,      U_FETCH,     1'b0);
            U_SRCH_TST:  w = mk(A_NONE,        C_STEP_ZERO, U_SWEEP_SET, 1'b0);
            U_SRCH_MOVE: w = mk(A_MOVE_PROBE,  C_ALWAYS,    U_SLEW,      1'b0);
            U_SWEEP_SET: w = mk(A_SWEEP_SET,   C_NEXT,      U_FETCH,     1'b0);
            U_SWEEP_GO:  w = mk(A_EMIT_SWL,    C_ALWAYS,    U_FETCH,     1'b1);
            U_FIN_APP:   w = mk(A_FIN_APPLIED, C_ALWAYS,    U_FETCH,     1'b1);
            U_SWP:       w = mk(A_NONE,        C_MATCH,     U_FIN_SWL,   1'b0);
            U_SWP_DEV:   w = mk(A_DEV,         C_NEXT,      U_FETCH,     1'b0);
            U_SWP_TST:   w = mk(A_NONE,        C_SWEEP_END, U_FIN_BEST,  1'b0);
            U_SWP_NEXT:  w = mk(A_INC_SWL,     C_ALWAYS,    U_FETCH,     1'b1);
            U_FIN_SWL:   w = mk(A_FIN_SWL,     C_ALWAYS,    U_FETCH,     1'b1);
            U_FIN_BEST:  w = mk(A_FIN_BEST,    C_ALWAYS,    U_FETCH,     1'b1);
            default:     w = mk(A_NONE,        C_ALWAYS,    U_FETCH,     1'b0);
        endcase
        return w;
    endfunction

endpackage

[rtl/otc_if.sv]
// Valid/ready channel interfaces for the calibrator's items and results.
// Depends on otc_pkg for the field widths.

interface otc_item_if
    import otc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [7:0]           range_low;
    logic [7:0]           range_high;
    logic [7:0]           present_trim;
    logic [TICK_BITS-1:0] measured_ticks;

    modport source (output valid, output opcode, output range_low, output range_high,
                    output present_trim, output measured_ticks, input ready);
    modport sink   (input valid, input opcode, input range_low, input range_high,
                    input present_trim, input measured_ticks, output ready);
endinterface

interface otc_result_if
    import otc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [TRIM_BITS-1:0] trim_value;
    logic                 measure_now;
    logic                 finished;
    logic                 succeeded;

    modport source (output valid, output trim_value, output measure_now, output finished,
                    output succeeded, input ready);
    modport sink   (input valid, input trim_value, input measure_now, input finished,
                    input succeeded, output ready);
endinterface

[rtl/otc_seq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on otc_pkg for the control word, the flag group and the program.

module otc_seq
    import otc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  otc_flags_t flags,
    output otc_ctrl_t  ctrl,
    output logic       at_fetch
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    assign ctrl     = otc_rom(upc_reg);
    assign at_fetch = (upc_reg == U_FETCH);

    always_comb
    begin
        case (ctrl.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = flags.no_input;
            C_OP_START:  take = flags.op_start;
            C_PH_SEARCH: take = flags.ph_search;
            C_PH_SWEEP:  take = flags.ph_sweep;
            C_FAR:       take = flags.far;
            C_MATCH:     take = flags.match;
            C_STEP_ZERO: take = flags.step_zero;
            C_SWEEP_END: take = flags.sweep_end;
            default:     take = 1'b1;
        endcase
        if (!adv)
            upc_next = upc_reg;
        else if (take)
            upc_next = ctrl.target;
        else
            upc_next = upc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= U_FETCH;
        else
            upc_reg <= upc_next;
    end

endmodule

[rtl/oscillator_trim_calibrator.sv]
// Oscillator trim calibrator: top level with the datapath and the result register.
// Depends on otc_pkg, the channel interfaces in otc_if and the sequencer otc_seq.

// A start transaction gives the search range and the trim now applied; each
// measurement transaction then reports the tick count at the current probe.
// A microcoded sequencer works through one transaction at a time, one control
// step per cycle unless a stalled result holds it, so the item channel is ready
// only while it waits for the next transaction. A start slews the trim to the
// first probe in at most 64 writes; a search measurement gives its slewed writes
// or one final or sweep write; a sweep measurement gives one write; a
// measurement while idle gives no result. The trim writes of a slew come one per
// cycle, while the result is taken, from a single registered result stage; a
// stalled result holds the sequencer.

module oscillator_trim_calibrator
    import otc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    otc_item_if.sink              item,
    otc_result_if.source          result
);

    logic [TICK_BITS-1:0] target_reg;
    logic [TICK_BITS-1:0] tolerance_reg;
    logic [STEP_BITS-1:0] max_step_reg;

    logic                 op_reg;
    logic [TRIM_BITS-1:0] in_lo_reg;
    logic [TRIM_BITS-1:0] in_hi_reg;
    logic [TRIM_BITS-1:0] in_present_reg;
    logic [TICK_BITS-1:0] ticks_reg;

    logic [1:0]           phase_reg;
    logic [TRIM_BITS-1:0] lo_reg;
    logic [TRIM_BITS-1:0] hi_reg;
    logic [TRIM_BITS-1:0] applied_reg;
    logic [TRIM_BITS-1:0] probe_reg;
    logic [TRIM_BITS-1:0] step_reg;
    logic [TRIM_BITS-1:0] swl_reg;
    logic [TRIM_BITS-1:0] swh_reg;
    logic [TRIM_BITS-1:0] best_reg;
    logic [TICK_BITS-1:0] least_reg;

    logic                 out_valid_reg;
    logic [TRIM_BITS-1:0] out_trim_reg;
    logic                 out_measure_reg;
    logic                 out_finished_reg;
    logic                 out_succeeded_reg;

    otc_ctrl_t            ctrl;
    otc_flags_t           flags;
    logic                 at_fetch;
    logic                 adv;

    logic [STEP_BITS-1:0] lim;
    logic [TRIM_BITS-1:0] diff;
    logic [TRIM_BITS-1:0] slew_trim;
    logic                 far;
    logic [TRIM_BITS:0]   span;
    logic [TRIM_BITS:0]   lo_plus2;
    logic [TRIM_BITS:0]   probe_plus2;
    logic [TICK_BITS-1:0] dev;
    logic [TRIM_BITS-1:0] swl_inc;

    logic                 emit_meas;
    logic                 emit_fin;
    logic                 emit_succ;
    logic [TRIM_BITS-1:0] emit_trim;

    // Slew arithmetic: the step limit never drops below the floor that keeps a
    // full-scale move within 64 writes.
    always_comb
    begin
        lim         = (max_step_reg < STEP_FLOOR) ? STEP_FLOOR : max_step_reg;
        diff        = (applied_reg > probe_reg) ? applied_reg - probe_reg
                                                : probe_reg - applied_reg;
        far         = ({{(STEP_BITS){1'b0}}, diff} > {{(TRIM_BITS){1'b0}}, lim});
        if (!far)
            slew_trim = probe_reg;
        else if (applied_reg > probe_reg)
            slew_trim = applied_reg - TRIM_BITS'(lim);
        else
            slew_trim = applied_reg + TRIM_BITS'(lim);
        span        = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
        lo_plus2    = {1'b0, lo_reg} + 2'd2;
        probe_plus2 = {1'b0, probe_reg} + 2'd2;
        dev         = (ticks_reg < target_reg) ? target_reg - ticks_reg
                                               : ticks_reg - target_reg;
        swl_inc     = swl_reg + 1'b1;
    end

    always_comb
    begin
        flags.no_input  = !item.valid;
        flags.op_start  = (op_reg == OP_START);
        flags.ph_search = (phase_reg == PH_SEARCH);
        flags.ph_sweep  = (phase_reg == PH_SWEEP);
        flags.far       = far;
        flags.match     = (ticks_reg == target_reg);
        flags.step_zero = (step_reg == '0);
        flags.sweep_end = (swl_reg >= swh_reg);
    end

    assign adv = !(ctrl.emit && out_valid_reg && !result.ready);

    otc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .flags    (flags),
        .ctrl     (ctrl),
        .at_fetch (at_fetch)
    );

    assign item.ready = at_fetch;

    always_comb
    begin
        emit_meas = 1'b1;
        emit_fin  = 1'b0;
        emit_succ = 1'b0;
        case (ctrl.action)
            A_SLEW:
            begin
                emit_trim = slew_trim;
                emit_meas = !far;
            end
            A_EMIT_SWL:    emit_trim = swl_reg;
            A_INC_SWL:     emit_trim = swl_inc;
            A_FIN_APPLIED:
            begin
                emit_trim = applied_reg;
                emit_meas = 1'b0;
                emit_fin  = 1'b1;
                emit_succ = 1'b1;
            end
            A_FIN_SWL:
            begin
                emit_trim = swl_reg;
                emit_meas = 1'b0;
                emit_fin  = 1'b1;
                emit_succ = 1'b1;
            end
            A_FIN_BEST:
            begin
                emit_trim = best_reg;
                emit_meas = 1'b0;
                emit_fin  = 1'b1;
                emit_succ = (least_reg < tolerance_reg);
            end
            default:       emit_trim = applied_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RESET;
            tolerance_reg <= TOLERANCE_RESET;
            max_step_reg  <= MAX_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TARGET:    target_reg    <= cfg_data;
                CFG_TOLERANCE: tolerance_reg <= cfg_data;
                CFG_MAX_STEP:  max_step_reg  <= cfg_data[STEP_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && at_fetch)
        begin
            op_reg         <= item.opcode;
            in_lo_reg      <= item.range_low;
            in_hi_reg      <= item.range_high;
            in_present_reg <= item.present_trim;
            ticks_reg      <= item.measured_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            lo_reg      <= '0;
            hi_reg      <= '0;
            applied_reg <= '0;
            probe_reg   <= '0;
            step_reg    <= '0;
            swl_reg     <= '0;
            swh_reg     <= '0;
            best_reg    <= '0;
            least_reg   <= DEV_NONE;
        end
        else if (adv)
        begin
            case (ctrl.action)
                A_INIT_RANGE:
                begin
                    lo_reg      <= in_lo_reg;
                    hi_reg      <= (in_hi_reg < in_lo_reg) ? in_lo_reg : in_hi_reg;
                    applied_reg <= in_present_reg;
                    phase_reg   <= PH_SEARCH;
                end
                A_INIT_PROBE:
                begin
                    step_reg  <= span[TRIM_BITS:1];
                    probe_reg <= lo_reg + span[TRIM_BITS:1];
                end
                A_SLEW:       applied_reg <= slew_trim;
                A_HALVE:      step_reg <= step_reg >> 1;
                A_MOVE_PROBE:
                    probe_reg <= (ticks_reg < target_reg) ? probe_reg + step_reg
                                                          : probe_reg - step_reg;
                A_SWEEP_SET:
                begin
                    swl_reg   <= ({1'b0, probe_reg} > lo_plus2) ? probe_reg - 2'd2 : lo_reg;
                    swh_reg   <= (probe_plus2 < {1'b0, hi_reg}) ? probe_plus2[TRIM_BITS-1:0]
                                                                : hi_reg;
                    best_reg  <= probe_reg;
                    least_reg <= DEV_NONE;
                    phase_reg <= PH_SWEEP;
                end
                A_EMIT_SWL:   applied_reg <= swl_reg;
                A_FIN_APPLIED: phase_reg <= PH_IDLE;
                A_DEV:
                begin
                    if (dev <= least_reg)
                    begin
                        least_reg <= dev;
                        best_reg  <= swl_reg;
                    end
                end
                A_INC_SWL:
                begin
                    swl_reg     <= swl_inc;
                    applied_reg <= swl_inc;
                end
                A_FIN_SWL:
                begin
                    applied_reg <= swl_reg;
                    phase_reg   <= PH_IDLE;
                end
                A_FIN_BEST:
                begin
                    applied_reg <= best_reg;
                    phase_reg   <= PH_IDLE;
                end
                default:      ;
            endcase
        end
    end

    // Result register: filled by an emitting step, emptied when the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit && adv)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit && adv)
        begin
            out_trim_reg      <= emit_trim;
            out_measure_reg   <= emit_meas;
            out_finished_reg  <= emit_fin;
            out_succeeded_reg <= emit_succ;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.trim_value  = out_trim_reg;
    assign result.measure_now = out_measure_reg;
    assign result.finished    = out_finished_reg;
    assign result.succeeded   = out_succeeded_reg;

endmodule

[rtl/otc_checker.sv]
// Port-level assertions for the oscillator trim calibrator, bound to its top level.
// Depends on otc_pkg for the trim width.

module otc_checker
    import otc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [TRIM_BITS-1:0] trim_value,
    input logic                 measure_now,
    input logic                 finished,
    input logic                 succeeded
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(trim_value)
            && $stable(finished) && $stable(succeeded) && $stable(measure_now))
        else $error("stalled result changed");

    // The block works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted on consecutive cycles");

    // A final write never asks for a measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && finished |-> !measure_now)
        else $error("final result with measure request");

    // Success is only reported together with the end of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && succeeded |-> finished)
        else $error("success flag without finish");

endmodule

bind oscillator_trim_calibrator otc_checker u_otc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .trim_value   (result.trim_value),
    .measure_now  (result.measure_now),
    .finished     (result.finished),
    .succeeded    (result.succeeded)
);

[tb/otc_trim_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the oscillator trim calibrator: watches the item channel, the result channel
// and the register port, predicts every trim write and compares it field by field.
// Depends on otc_pkg and the channel interfaces in otc_if.

module otc_trim_checker
    import otc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    otc_item_if                   item,
    otc_result_if                 result,
    output int                    failures,
    output int                    outstanding
);

    localparam int TRIM_TOP = int'(TRIM_MAX);

    typedef struct packed {
        logic [TRIM_BITS-1:0] trim_value;
        logic                 measure_now;
        logic                 finished;
        logic                 succeeded;
    } trim_write_t;

    trim_write_t expected_writes[$];
    trim_write_t oldest;

    // Register copies
    logic [TICK_BITS-1:0] goal_count;
    logic [TICK_BITS-1:0] slack_count;
    logic [STEP_BITS-1:0] max_step;

    // Calibration state
    logic [1:0] run_phase;
    int applied_trim;
    int probe_trim;
    int half_span;
    int cursor;
    int sweep_top;
    int best_trim;
    int least_dev;
    int span_lo;
    int span_hi;

    function automatic void expect_write(input int trim, input logic meas, input logic fin,
                                         input logic ok);
        trim_write_t w;
        w.trim_value  = TRIM_BITS'(trim);
        w.measure_now = meas;
        w.finished    = fin;
        w.succeeded   = ok;
        expected_writes.push_back(w);
    endfunction

    function automatic void close_run(input int trim, input logic ok);
        applied_trim = trim & TRIM_TOP;
        run_phase    = PH_IDLE;
        expect_write(trim, 1'b0, 1'b1, ok);
    endfunction

    // Moves the applied trim to the probe in steps no larger than the slew limit; the
    // last write of the move asks for a measurement.
    function automatic void slew_toward_probe();
        int limit;
        int now_at;
        int diff;
        int writes;
        limit = int'(max_step);
        if (limit < int'(STEP_FLOOR))
            limit = int'(STEP_FLOOR);
        if (limit < 1)
            limit = 1;
        now_at = applied_trim;
        writes = 0;
        if (now_at == probe_trim) begin
            expect_write(probe_trim, 1'b1, 1'b0, 1'b0);
            return;
        end
        while (now_at != probe_trim && writes < 64) begin
            diff = (now_at > probe_trim) ? now_at - probe_trim : probe_trim - now_at;
            if (diff > limit)
                now_at = (now_at > probe_trim) ? now_at - limit : now_at + limit;
            else
                now_at = probe_trim;
            expect_write(now_at, now_at == probe_trim, 1'b0, 1'b0);
            writes++;
        end
        applied_trim = now_at;
    endfunction

    function automatic void begin_calibration(input int lo, input int hi, input int present);
        span_lo      = lo;
        span_hi      = (hi < lo) ? lo : hi;
        applied_trim = present;
        half_span    = (span_hi - span_lo + 1) / 2;
        probe_trim   = (span_lo + half_span) & TRIM_TOP;
        run_phase    = PH_SEARCH;
        slew_toward_probe();
    endfunction

    function automatic void apply_measurement(input int ticks);
        int goal;
        int dev;
        goal = int'(goal_count);
        case (run_phase)
            PH_SEARCH: begin
                if (ticks == goal) begin
                    close_run(applied_trim, 1'b1);
                end
                else begin
                    half_span = half_span / 2;
                    if (half_span != 0) begin
                        if (ticks < goal)
                            probe_trim = (probe_trim + half_span) & TRIM_TOP;
                        else
                            probe_trim = (probe_trim - half_span) & TRIM_TOP;
                        slew_toward_probe();
                    end
                    else begin
                        // Search exhausted: sweep two either side of the probe, within range.
                        cursor       = (probe_trim > span_lo + 2) ? probe_trim - 2 : span_lo;
                        sweep_top    = (probe_trim + 2 < span_hi) ? probe_trim + 2 : span_hi;
                        best_trim    = probe_trim;
                        least_dev    = int'(DEV_NONE);
                        run_phase    = PH_SWEEP;
                        applied_trim = cursor;
                        expect_write(cursor, 1'b1, 1'b0, 1'b0);
                    end
                end
            end
            PH_SWEEP: begin
                if (ticks == goal) begin
                    close_run(cursor, 1'b1);
                end
                else begin
                    dev = (ticks < goal) ? goal - ticks : ticks - goal;
                    // A later point wins a tie.
                    if (dev <= least_dev) begin
                        least_dev = dev;
                        best_trim = cursor;
                    end
                    if (cursor >= sweep_top) begin
                        close_run(best_trim, least_dev < int'(slack_count));
                    end
                    else begin
                        cursor       = (cursor + 1) & TRIM_TOP;
                        applied_trim = cursor;
                        expect_write(cursor, 1'b1, 1'b0, 1'b0);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [TRIM_BITS-1:0] want,
                                          input logic [TRIM_BITS-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            goal_count      = TARGET_RESET;
            slack_count     = TOLERANCE_RESET;
            max_step        = MAX_STEP_RESET;
            run_phase       = PH_IDLE;
            applied_trim    = 0;
            probe_trim      = 0;
            half_span       = 0;
            cursor          = 0;
            sweep_top       = 0;
            best_trim       = 0;
            least_dev       = int'(DEV_NONE);
            span_lo         = 0;
            span_hi         = 0;
            expected_writes.delete();
            failures        = 0;
            outstanding    <= 0;
        end
        else begin
            // Results first: anything accepted now belongs to an earlier transaction.
            if (result.valid && result.ready) begin
                if (expected_writes.size() == 0) begin
                    $error("trim_value %0d arrived with no write expected", result.trim_value);
                    failures++;
                end
                else begin
                    oldest = expected_writes.pop_front();
                    compare_field("trim_value", oldest.trim_value, result.trim_value);
                    compare_field("measure_now", TRIM_BITS'(oldest.measure_now),
                                  TRIM_BITS'(result.measure_now));
                    compare_field("finished", TRIM_BITS'(oldest.finished),
                                  TRIM_BITS'(result.finished));
                    compare_field("succeeded", TRIM_BITS'(oldest.succeeded),
                                  TRIM_BITS'(result.succeeded));
                end
            end
            if (cfg_write) begin
                case (cfg_index)
                    CFG_TARGET:    goal_count  = cfg_data;
                    CFG_TOLERANCE: slack_count = cfg_data;
                    CFG_MAX_STEP:  max_step    = cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready) begin
                if (item.opcode == OP_START)
                    begin_calibration(int'(item.range_low), int'(item.range_high),
                                      int'(item.present_trim));
                else
                    apply_measurement(int'(item.measured_ticks));
            end
            outstanding <= expected_writes.size();
        end
    end

endmodule

[tb/tb_oscillator_trim_calibrator.sv]
`timescale 1ns / 100ps
// Top of the oscillator trim calibrator testbench: clock, reset, register writes and the
// stimulus and drain sides of both channels; the verdict comes from otc_trim_checker.
// Depends on otc_pkg, otc_if, the calibrator RTL and otc_trim_checker.

module tb_oscillator_trim_calibrator
    import otc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int failures;
    int outstanding;
    int runs_finished = 0;
    int items_sent    = 0;
    int cur_target    = int'(TARGET_RESET);
    int gap_window    = 0;
    bit gap_steady    = 1'b0;
    bit calm          = 1'b0;
    bit pressure_due  = 1'b0;

    otc_item_if   item_ch ();
    otc_result_if result_ch ();

    oscillator_trim_calibrator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    otc_trim_checker trim_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item_ch),
        .result      (result_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stall bursts, steady windows, and one long hold that backs the
    // block up into its item channel.
    initial begin : result_drain
        int stall_left;
        int window_left;
        bit steady;
        bit pressure_done;
        stall_left    = 0;
        window_left   = 0;
        steady        = 1'b0;
        pressure_done = 1'b0;
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (window_left == 0) begin
                window_left = $urandom_range(40, 250);
                steady      = ($urandom_range(0, 2) == 0);
            end
            window_left--;
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (pressure_due && !pressure_done) begin
                pressure_done = 1'b1;
                stall_left    = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && !steady && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 10);
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (result_ch.valid && result_ch.ready && result_ch.finished)
                runs_finished <= runs_finished + 1;
        end
    end

    task automatic offer(input logic op, input int lo, input int hi, input int present,
                         input int ticks);
        if (!calm) begin
            if (gap_window == 0) begin
                gap_window = $urandom_range(20, 120);
                gap_steady = ($urandom_range(0, 2) == 0);
            end
            gap_window--;
            if (!gap_steady && $urandom_range(0, 3) == 0) begin
                item_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= op;
        item_ch.range_low      <= 8'(lo);
        item_ch.range_high     <= 8'(hi);
        item_ch.present_trim   <= 8'(present);
        item_ch.measured_ticks <= TICK_BITS'(ticks);
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic configure(input int tgt, input int tol, input int stp);
        cfg_write <= 1'b1;
        cfg_index <= CFG_TARGET;
        cfg_data  <= CFG_DATA_W'(tgt);
        @(posedge clk);
        cfg_index <= CFG_TOLERANCE;
        cfg_data  <= CFG_DATA_W'(tol);
        @(posedge clk);
        cfg_index <= CFG_MAX_STEP;
        cfg_data  <= CFG_DATA_W'(stp);
        @(posedge clk);
        cfg_write  <= 1'b0;
        cur_target = tgt;
    endtask

    // Waits for every predicted write, then gives an ignored measurement time to retire.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly near the target so that the search and sweep see realistic counts.
    function automatic int pick_ticks();
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 8)
            return cur_target;
        if (r < 60) begin
            t = cur_target + int'($urandom_range(0, 40)) - 20;
            if (t < 0)
                t = 0;
            if (t > 65535)
                t = 65535;
            return t;
        end
        return $urandom_range(0, 65535);
    endfunction

    task automatic calibration_run();
        int shape;
        int lo;
        int hi;
        int widen;
        int baseline;
        int budget;
        int m;
        shape = $urandom_range(0, 9);
        lo    = $urandom_range(0, 255);
        widen = $urandom_range(0, 40);
        if (shape == 0) begin
            lo = 0;
            hi = 255;
        end
        else if (shape == 1) begin
            hi = $urandom_range(0, 255);
        end
        else if (shape == 2) begin
            lo = $urandom_range(200, 255);
            hi = 255;
        end
        else begin
            hi = (lo + widen > 255) ? 255 : lo + widen;
        end
        offer(OP_START, lo, hi, $urandom_range(0, 255), $urandom_range(0, 65535));
        baseline = runs_finished;
        // Now and then a run is cut short by the next start.
        budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 24;
        for (m = 0; m < budget && runs_finished == baseline; m++)
            offer(OP_MEASURE, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255), pick_ticks());
    endtask

    task automatic random_phase(input int count, input int calm_after, input int hold_after);
        int first;
        first = items_sent;
        while (items_sent - first < count) begin
            if (items_sent - first >= calm_after)
                calm = 1'b1;
            if (items_sent - first >= hold_after)
                pressure_due = 1'b1;
            calibration_run();
        end
    endtask

    initial begin : stimulus
        rst_n                  <= 1'b0;
        cfg_write              <= 1'b0;
        cfg_index              <= CFG_TARGET;
        cfg_data               <= '0;
        item_ch.valid          <= 1'b0;
        item_ch.opcode         <= OP_START;
        item_ch.range_low      <= '0;
        item_ch.range_high     <= '0;
        item_ch.present_trim   <= '0;
        item_ch.measured_ticks <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed runs with the reset register values.
        offer(OP_MEASURE, 0, 0, 0, 0);
        offer(OP_START, 0, 255, 0, 16'hA5A5);
        offer(OP_MEASURE, 255, 255, 255, 65535);
        offer(OP_MEASURE, 0, 0, 0, 0);
        offer(OP_START, 200, 10, 128, 0);
        offer(OP_MEASURE, 0, 0, 0, 990);
        offer(OP_MEASURE, 0, 0, 0, 1000);
        offer(OP_START, 255, 255, 255, 16'h5A5A);
        offer(OP_MEASURE, 0, 0, 0, 1234);
        offer(OP_MEASURE, 0, 0, 0, 1010);
        offer(OP_START, 10, 20, 15, 0);
        offer(OP_MEASURE, 0, 0, 0, 500);
        offer(OP_MEASURE, 0, 0, 0, 1500);
        offer(OP_MEASURE, 0, 0, 0, 2000);
        offer(OP_MEASURE, 0, 0, 0, 1003);
        offer(OP_MEASURE, 0, 0, 0, 997);
        offer(OP_MEASURE, 0, 0, 0, 1005);
        offer(OP_MEASURE, 0, 0, 0, 1100);
        offer(OP_MEASURE, 0, 0, 0, 900);
        offer(OP_START, 0, 3, 250, 0);
        offer(OP_MEASURE, 0, 0, 0, 1000);
        offer(OP_MEASURE, 0, 0, 0, 1000);
        drain_results();

        configure(65535, 1, 255);
        random_phase(110, 1000, 1000);
        drain_results();

        configure(1, 65535, 4);
        random_phase(110, 1000, 40);
        drain_results();

        configure($urandom_range(1, 65535), $urandom_range(1, 300), 2);
        random_phase(100, 1000, 1000);
        drain_results();

        configure($urandom_range(500, 3000), $urandom_range(5, 50), $urandom_range(4, 64));
        random_phase(110, 60, 1000);
        drain_results();

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
